[sv/dsfd_pkg.sv]
// Shared types and constants for the particulate sensor frame decoder.
// No dependencies; dsfd_check and the top level import this package.
`default_nettype none

package dsfd_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned CntW     = $clog2(FrameLen + 1);

  localparam logic [7:0] HeadByte = 8'hAA;
  localparam logic [7:0] CmdByte  = 8'hC0;
  localparam logic [7:0] TailByte = 8'hAB;

  typedef logic [7:0] byte_t;
  typedef byte_t frame_t [FrameLen];
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] fine;
    logic [15:0] coarse;
  } chk_t;

endpackage

`default_nettype wire

[sv/dsfd_if.sv]
// Handshake channels of the frame decoder: received bytes in, readings out.
// No dependencies.
`default_nettype none

interface dsfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfd_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] fine_dust_tenths;
  logic [15:0] coarse_dust_tenths;

  modport source (output valid, output fine_dust_tenths, output coarse_dust_tenths,
                  input ready);
  modport sink (input valid, input fine_dust_tenths, input coarse_dust_tenths,
                output ready);
endinterface

`default_nettype wire

[sv/dsfd_check.sv]
// Frame check: head, command, tail and checksum over a ten-byte window.
// Depends on dsfd_pkg.
`default_nettype none

module dsfd_check (
  input  dsfd_pkg::byte_t frame_i [dsfd_pkg::FrameLen],
  input  logic            full_i,
  output dsfd_pkg::chk_t  chk_o
);
  import dsfd_pkg::*;

  byte_t sum_lo;
  byte_t sum_hi;
  byte_t sum;

  assign sum_lo = frame_i[2] + frame_i[3] + frame_i[4];
  assign sum_hi = frame_i[5] + frame_i[6] + frame_i[7];
  assign sum    = sum_lo + sum_hi;

  always_comb begin
    chk_o.ok     = full_i && (frame_i[0] == HeadByte) && (frame_i[1] == CmdByte) &&
                   (frame_i[9] == TailByte) && (sum == frame_i[8]);
    chk_o.fine   = {frame_i[3], frame_i[2]};
    chk_o.coarse = {frame_i[5], frame_i[4]};
  end

endmodule

`default_nettype wire

[sv/dust_sensor_frame_decoder.sv]
// Top level of the particulate sensor frame decoder.
// Depends on dsfd_pkg, dsfd_if.sv and dsfd_check.
//
//   channel  dir  payload                                   transfer when
//   rx_i     in   rx_byte [7:0]                             valid && ready
//   res_o    out  fine_dust_tenths, coarse_dust_tenths     valid && ready
//
// One byte per cycle unless the input is stalled. A byte enters the window
// register on its transfer; the check runs in the next cycle and a good
// frame loads the result register. Reset empties the pipeline and the fill
// count; window contents need no reset. A stalled result holds the check
// stage, and the input stalls only when both are full.
`default_nettype none

module dust_sensor_frame_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  dsfd_rx_if.sink    rx_i,
  dsfd_res_if.source res_o
);
  import dsfd_pkg::*;

  byte_t  frame_q [FrameLen];
  cnt_t   count_q;
  cnt_t   count_d;
  logic   chk_valid_q;
  logic   chk_valid_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   [15:0] fine_q;
  logic   [15:0] coarse_q;
  logic   out_free;
  logic   in_xfer;
  logic   full;
  chk_t   chk;

  assign out_free = !out_valid_q || res_o.ready;
  assign rx_i.ready = !chk_valid_q || out_free;
  assign in_xfer = rx_i.valid && rx_i.ready;
  assign full = (count_q == cnt_t'(FrameLen));

  dsfd_check u_check (
    .frame_i (frame_q),
    .full_i  (full),
    .chk_o   (chk)
  );

  always_comb begin
    count_d = count_q;
    if (in_xfer && !full) begin
      count_d = count_q + cnt_t'(1);
    end
    chk_valid_d = chk_valid_q;
    if (in_xfer) begin
      chk_valid_d = 1'b1;
    end else if (out_free) begin
      chk_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = chk_valid_q && chk.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < FrameLen - 1; i++) begin
        frame_q[i] <= frame_q[i+1];
      end
      frame_q[FrameLen-1] <= rx_i.rx_byte;
    end
    if (out_free && chk_valid_q && chk.ok) begin
      fine_q   <= chk.fine;
      coarse_q <= chk.coarse;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.fine_dust_tenths   = fine_q;
  assign res_o.coarse_dust_tenths = coarse_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(FrameLen))
    else $error("fill count beyond frame length");

  a_result_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_free && chk_valid_q && !full) |=> !out_valid_q)
    else $error("result from a partly filled window");

  a_result_from_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_free && !chk_valid_q) |=> !out_valid_q)
    else $error("result without a checked byte");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chk_valid_q |-> rx_i.ready)
    else $error("input stalled with empty check stage");

endmodule

`default_nettype wire
